FILE: rtl/position_to_attitude_rotation_defines.svh
// assertion macros for the position to attitude rotation block
`ifndef POSITION_TO_ATTITUDE_ROTATION_DEFINES_SVH
`define POSITION_TO_ATTITUDE_ROTATION_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, quiet while reset is low
`define P2A_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("p2a assertion failed");
// checked property, also during reset
`define P2A_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("p2a assertion failed");
`else
`define P2A_ASSERT(lbl, clk, rst_n, prop)
`define P2A_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/p2a_pkg.sv
// shared types, constants and sine table builder for the position to attitude rotation
package p2a_pkg;

  localparam int ANGLE_BITS_DEF       = 16;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PADDR_W              = 4;
  localparam int CORDIC_STEPS         = 30;

  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam longint Q30_ONE         = 64'sd1073741824;

  // register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_LOWER = 2'd2;

  // mode codes
  localparam logic MODE_FULL = 1'b0;
  localparam logic MODE_YAW  = 1'b1;

  localparam logic signed [31:0] UPPER_RESET = 32'sd1966080;
  localparam logic signed [31:0] LOWER_RESET = -32'sd1966080;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [31:0] x_correction;
    logic signed [31:0] y_correction;
  } in_t;

  typedef struct packed {
    logic signed [31:0] roll_command;
    logic signed [31:0] pitch_command;
    logic               limit_hit;
  } out_t;

  typedef struct packed {
    logic               mode_select;
    logic signed [31:0] command_upper_limit;
    logic signed [31:0] command_lower_limit;
  } cfg_t;

  // sine of one turn fraction in Q2.30, evaluated at elaboration to fill the table
  function automatic logic signed [31:0] cordic_sin(input logic [31:0] turn);
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    logic [31:0] t;
    logic        neg;
    int          i;
    x   = CORDIC_GAIN_Q30;
    y   = 0;
    t   = turn;
    neg = 1'b0;
    if (t >= 32'h4000_0000 && t < 32'hC000_0000) begin
      t   = t - 32'h8000_0000;
      neg = 1'b1;
    end
    z = longint'(signed'(t));
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    if (y > Q30_ONE) y = Q30_ONE;
    if (y < -Q30_ONE) y = -Q30_ONE;
    if (neg) y = -y;
    return 32'(y);
  endfunction

endpackage

FILE: rtl/p2a_cfg.sv
// configuration register file on the apb-style port
module p2a_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [p2a_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output p2a_pkg::cfg_t                cfg_o
);

  p2a_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_select         <= p2a_pkg::MODE_FULL;
      cfg_q.command_upper_limit <= p2a_pkg::UPPER_RESET;
      cfg_q.command_lower_limit <= p2a_pkg::LOWER_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        p2a_pkg::REG_MODE:  cfg_q.mode_select         <= pwdata[0];
        p2a_pkg::REG_UPPER: cfg_q.command_upper_limit <= signed'(pwdata);
        p2a_pkg::REG_LOWER: cfg_q.command_lower_limit <= signed'(pwdata);
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      p2a_pkg::REG_MODE:  prdata = {31'd0, cfg_q.mode_select};
      p2a_pkg::REG_UPPER: prdata = cfg_q.command_upper_limit;
      p2a_pkg::REG_LOWER: prdata = cfg_q.command_lower_limit;
      default:            prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/p2a_trig_rom.sv
// sine or cosine lookup: angle to table index, constant table, registered read
module p2a_trig_rom #(
  parameter int   ANGLE_BITS       = p2a_pkg::ANGLE_BITS_DEF,
  parameter int   SINE_TABLE_DEPTH = p2a_pkg::SINE_TABLE_DEPTH_DEF,
  parameter logic QUARTER          = 1'b0
) (
  input  logic               clk_i,
  input  logic [15:0]        angle_i,
  output logic signed [31:0] data_o
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W = ANGLE_BITS + IDX_W + 1;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [ANGLE_BITS-1:0] phase;
  logic [ANGLE_BITS-1:0] phase_sh;
  logic [PROD_W-1:0]     prod;
  logic [IDX_W-1:0]      idx;
  logic signed [31:0]    tab [SINE_TABLE_DEPTH];
  logic signed [31:0]    data_q;

  // rescale the angle word to a phase of ANGLE_BITS bits
  if (ANGLE_BITS >= 16) begin : g_up
    assign phase = ANGLE_BITS'(angle_i) << (ANGLE_BITS - 16);
  end else begin : g_down
    assign phase = ANGLE_BITS'(angle_i >> (16 - ANGLE_BITS));
  end

  // cosine reads a quarter turn ahead
  assign phase_sh = QUARTER ? phase + QTR : phase;
  assign prod     = PROD_W'(phase_sh) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx      = prod[ANGLE_BITS +: IDX_W];

  // constant sine table over one full turn
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] TURN = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
    localparam logic signed [31:0] ENTRY = p2a_pkg::cordic_sin(TURN[31:0]);
    assign tab[k] = ENTRY;
  end

  // registered read
  always_ff @(posedge clk_i) begin
    data_q <= tab[idx];
  end

  assign data_o = data_q;

endmodule

FILE: rtl/position_to_attitude_rotation.sv
// top level: eight-stage rotation pipeline from position correction to attitude setpoint
// throughput: one word per cycle; busy stays low, every start is taken
// each stage holds at most one multiply or one wide add with rounding
// reset clears the stage valid bits and the configuration registers (mode 0, limits +-30.0)
// results are shown for one cycle on done_o; the receiver cannot stall
`include "position_to_attitude_rotation_defines.svh"

module position_to_attitude_rotation #(
  parameter int ANGLE_BITS       = p2a_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = p2a_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  p2a_pkg::in_t                cmd_i,
  output logic                        done_o,
  output p2a_pkg::out_t               result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [p2a_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int LAT = 8;
  localparam logic signed [63:0] RND30   = 64'sh2000_0000;
  localparam logic signed [63:0] RND24   = 64'sh0080_0000;
  localparam logic signed [66:0] RND30_W = 67'sh2000_0000;
  localparam logic signed [63:0] DEG_Q24 = 64'sd961263669;
  localparam logic signed [66:0] S32_MAX = 67'sd2147483647;
  localparam logic signed [66:0] S32_MIN = -67'sd2147483648;

  p2a_pkg::cfg_t cfg;
  logic [LAT:1]  v_q;
  logic          in_acc;

  // stage 1
  logic [15:0]        roll_s1_q, pitch_s1_q, yaw_s1_q;
  logic signed [31:0] x_s1_q, y_s1_q;
  logic               mode_s1_q;
  // stage 2
  logic signed [31:0] sr_s2, cr_s2, sp_s2, cp_s2, sy_s2, cy_s2;
  logic signed [31:0] x_s2_q, y_s2_q;
  logic               mode_s2_q;
  // stage 3
  logic signed [63:0] srsp_m_s3_q, cpsy_m_s3_q, crcy_m_s3_q, cpcy_m_s3_q, crsy_m_s3_q;
  logic signed [63:0] xsy_m_s3_q, ycy_m_s3_q, xcy_m_s3_q, ysy_m_s3_q;
  logic signed [31:0] sy_s3_q, cy_s3_q, x_s3_q, y_s3_q;
  logic               mode_s3_q;
  // stage 4
  logic signed [31:0] srsp_s4_q, a1_s4_q, crcy_s4_q, a2_s4_q, crsy_s4_q;
  logic signed [33:0] r_s4_q, p_s4_q;
  logic signed [31:0] sy_s4_q, cy_s4_q, x_s4_q, y_s4_q;
  logic               mode_s4_q;
  // stage 5
  logic signed [63:0] ssy_m_s5_q, scy_m_s5_q, rdeg_m_s5_q, pdeg_m_s5_q;
  logic signed [31:0] a1_s5_q, crcy_s5_q, a2_s5_q, crsy_s5_q, x_s5_q, y_s5_q;
  logic               mode_s5_q;
  // stage 6
  logic signed [32:0] b1_s6_q, b2_s6_q;
  logic signed [39:0] rd_s6_q, pd_s6_q;
  logic signed [31:0] a1_s6_q, a2_s6_q, x_s6_q, y_s6_q;
  logic               mode_s6_q;
  // stage 7
  logic signed [65:0] p1_s7_q, p2_s7_q, p3_s7_q, p4_s7_q;
  logic signed [31:0] clr_s7_q, clp_s7_q;
  logic               chit_s7_q;
  logic               mode_s7_q;
  logic signed [31:0] clr_d, clp_d;
  logic               hitr_d, hitp_d;
  logic signed [39:0] up40, lo40;
  // stage 8
  logic signed [66:0] sum_r, sum_p, rnd_r, rnd_p;
  logic signed [31:0] sat_r, sat_p;
  logic               sath_r, sath_p;
  p2a_pkg::out_t      result_q;
  logic               mode_s8_q;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // configuration registers
  p2a_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LAT-1:1], in_acc};
    end
  end

  // stage 1: capture the word
  always_ff @(posedge clk_i) begin
    roll_s1_q  <= cmd_i.roll_angle;
    pitch_s1_q <= cmd_i.pitch_angle;
    yaw_s1_q   <= cmd_i.yaw_angle;
    x_s1_q     <= cmd_i.x_correction;
    y_s1_q     <= cmd_i.y_correction;
    mode_s1_q  <= cfg.mode_select;
  end

  // stage 2: sine and cosine lookups
  p2a_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
                 .QUARTER(1'b0)) u_sin_roll (
    .clk_i(clk_i), .angle_i(roll_s1_q), .data_o(sr_s2));
  p2a_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
                 .QUARTER(1'b1)) u_cos_roll (
    .clk_i(clk_i), .angle_i(roll_s1_q), .data_o(cr_s2));
  p2a_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
                 .QUARTER(1'b0)) u_sin_pitch (
    .clk_i(clk_i), .angle_i(pitch_s1_q), .data_o(sp_s2));
  p2a_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
                 .QUARTER(1'b1)) u_cos_pitch (
    .clk_i(clk_i), .angle_i(pitch_s1_q), .data_o(cp_s2));
  p2a_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
                 .QUARTER(1'b0)) u_sin_yaw (
    .clk_i(clk_i), .angle_i(yaw_s1_q), .data_o(sy_s2));
  p2a_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
                 .QUARTER(1'b1)) u_cos_yaw (
    .clk_i(clk_i), .angle_i(yaw_s1_q), .data_o(cy_s2));

  always_ff @(posedge clk_i) begin
    x_s2_q    <= x_s1_q;
    y_s2_q    <= y_s1_q;
    mode_s2_q <= mode_s1_q;
  end

  // stage 3: first products
  always_ff @(posedge clk_i) begin
    srsp_m_s3_q <= sr_s2 * sp_s2;
    cpsy_m_s3_q <= cp_s2 * sy_s2;
    crcy_m_s3_q <= cr_s2 * cy_s2;
    cpcy_m_s3_q <= cp_s2 * cy_s2;
    crsy_m_s3_q <= cr_s2 * sy_s2;
    xsy_m_s3_q  <= x_s2_q * sy_s2;
    ycy_m_s3_q  <= y_s2_q * cy_s2;
    xcy_m_s3_q  <= x_s2_q * cy_s2;
    ysy_m_s3_q  <= y_s2_q * sy_s2;
    sy_s3_q     <= sy_s2;
    cy_s3_q     <= cy_s2;
    x_s3_q      <= x_s2_q;
    y_s3_q      <= y_s2_q;
    mode_s3_q   <= mode_s2_q;
  end

  // stage 4: round back to q30, yaw-only sums
  always_ff @(posedge clk_i) begin
    srsp_s4_q <= 32'((srsp_m_s3_q + RND30) >>> 30);
    a1_s4_q   <= 32'((cpsy_m_s3_q + RND30) >>> 30);
    crcy_s4_q <= 32'((crcy_m_s3_q + RND30) >>> 30);
    a2_s4_q   <= 32'((cpcy_m_s3_q + RND30) >>> 30);
    crsy_s4_q <= 32'((crsy_m_s3_q + RND30) >>> 30);
    r_s4_q    <= 34'((xsy_m_s3_q + ycy_m_s3_q + RND30) >>> 30);
    p_s4_q    <= 34'((xcy_m_s3_q - ysy_m_s3_q + RND30) >>> 30);
    sy_s4_q   <= sy_s3_q;
    cy_s4_q   <= cy_s3_q;
    x_s4_q    <= x_s3_q;
    y_s4_q    <= y_s3_q;
    mode_s4_q <= mode_s3_q;
  end

  // stage 5: second products, degree scaling
  always_ff @(posedge clk_i) begin
    ssy_m_s5_q  <= srsp_s4_q * sy_s4_q;
    scy_m_s5_q  <= srsp_s4_q * cy_s4_q;
    rdeg_m_s5_q <= 64'(r_s4_q) * DEG_Q24;
    pdeg_m_s5_q <= 64'(p_s4_q) * DEG_Q24;
    a1_s5_q     <= a1_s4_q;
    crcy_s5_q   <= crcy_s4_q;
    a2_s5_q     <= a2_s4_q;
    crsy_s5_q   <= crsy_s4_q;
    x_s5_q      <= x_s4_q;
    y_s5_q      <= y_s4_q;
    mode_s5_q   <= mode_s4_q;
  end

  // stage 6: y coefficients, degrees rounded to q16.16
  always_ff @(posedge clk_i) begin
    b1_s6_q   <= 33'((ssy_m_s5_q + RND30) >>> 30) + 33'(crcy_s5_q);
    b2_s6_q   <= 33'((scy_m_s5_q + RND30) >>> 30) - 33'(crsy_s5_q);
    rd_s6_q   <= 40'((rdeg_m_s5_q + RND24) >>> 24);
    pd_s6_q   <= 40'((pdeg_m_s5_q + RND24) >>> 24);
    a1_s6_q   <= a1_s5_q;
    a2_s6_q   <= a2_s5_q;
    x_s6_q    <= x_s5_q;
    y_s6_q    <= y_s5_q;
    mode_s6_q <= mode_s5_q;
  end

  // stage 7: clamp of yaw-only commands, upper limit first
  assign up40 = 40'(cfg.command_upper_limit);
  assign lo40 = 40'(cfg.command_lower_limit);

  always_comb begin
    hitr_d = 1'b1;
    hitp_d = 1'b1;
    if (rd_s6_q > up40) begin
      clr_d = cfg.command_upper_limit;
    end else if (rd_s6_q < lo40) begin
      clr_d = cfg.command_lower_limit;
    end else begin
      clr_d  = rd_s6_q[31:0];
      hitr_d = 1'b0;
    end
    if (pd_s6_q > up40) begin
      clp_d = cfg.command_upper_limit;
    end else if (pd_s6_q < lo40) begin
      clp_d = cfg.command_lower_limit;
    end else begin
      clp_d  = pd_s6_q[31:0];
      hitp_d = 1'b0;
    end
  end

  // stage 7: correction products
  always_ff @(posedge clk_i) begin
    p1_s7_q   <= 66'(a1_s6_q) * 66'(x_s6_q);
    p2_s7_q   <= 66'(b1_s6_q) * 66'(y_s6_q);
    p3_s7_q   <= 66'(a2_s6_q) * 66'(x_s6_q);
    p4_s7_q   <= 66'(b2_s6_q) * 66'(y_s6_q);
    clr_s7_q  <= clr_d;
    clp_s7_q  <= clp_d;
    chit_s7_q <= hitr_d || hitp_d;
    mode_s7_q <= mode_s6_q;
  end

  // stage 8: sum, round and saturate the full rotation
  always_comb begin
    sum_r  = 67'(p1_s7_q) + 67'(p2_s7_q);
    sum_p  = 67'(p3_s7_q) + 67'(p4_s7_q);
    rnd_r  = (sum_r + RND30_W) >>> 30;
    rnd_p  = (sum_p + RND30_W) >>> 30;
    sath_r = 1'b1;
    sath_p = 1'b1;
    if (rnd_r > S32_MAX) begin
      sat_r = S32_MAX[31:0];
    end else if (rnd_r < S32_MIN) begin
      sat_r = S32_MIN[31:0];
    end else begin
      sat_r  = rnd_r[31:0];
      sath_r = 1'b0;
    end
    if (rnd_p > S32_MAX) begin
      sat_p = S32_MAX[31:0];
    end else if (rnd_p < S32_MIN) begin
      sat_p = S32_MIN[31:0];
    end else begin
      sat_p  = rnd_p[31:0];
      sath_p = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    mode_s8_q <= mode_s7_q;
    if (mode_s7_q == p2a_pkg::MODE_YAW) begin
      result_q.roll_command  <= clr_s7_q;
      result_q.pitch_command <= clp_s7_q;
      result_q.limit_hit     <= chit_s7_q;
    end else begin
      result_q.roll_command  <= sat_r;
      result_q.pitch_command <= sat_p;
      result_q.limit_hit     <= sath_r || sath_p;
    end
  end

  assign done_o   = v_q[LAT];
  assign result_o = result_q;

  // every result stems from a word taken at the pipeline input
  `P2A_ASSERT(a_done_from_start, clk_i, rst_ni, done_o |-> $past(in_acc, LAT))
  // the mode travels with its word
  `P2A_ASSERT(a_mode_follows, clk_i, rst_ni, done_o |-> (mode_s8_q == $past(cfg.mode_select, LAT)))
  // a full-rotation saturation leaves a command at a bound
  `P2A_ASSERT(a_sat_bound, clk_i, rst_ni, (done_o && mode_s8_q == p2a_pkg::MODE_FULL && result_o.limit_hit) |-> (result_o.roll_command == 32'sh7fff_ffff || result_o.roll_command == 32'sh8000_0000 || result_o.pitch_command == 32'sh7fff_ffff || result_o.pitch_command == 32'sh8000_0000))
  // busy never blocks a word
  `P2A_ASSERT_ALWAYS(a_never_busy, clk_i, !busy)

endmodule
